/* sv/rpb_pkg.sv */
`timescale 1ns / 1ps

package rpb_pkg;

	localparam int CHAN_W = 8;
	localparam int MODE_W = 3;
	localparam int BASE_W = CHAN_W + 1;
	localparam int PROD_W = 2 * CHAN_W;
	localparam int SUM_W  = CHAN_W + 2;

	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

	localparam logic [MODE_W-1:0] MODE_OVER   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_COPY   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ADD    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_MUL    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_SCREEN = 3'd4;
	localparam logic [MODE_W-1:0] MODE_PREMUL = 3'd5;

	// control handed from the top level to each channel lane
	typedef struct packed {
		logic              en;
		logic [MODE_W-1:0] mode;
		logic              alpha_lane;
	} lane_ctrl_t;

endpackage

/* sv/rpb_lane.sv */
`timescale 1ns / 1ps

module rpb_lane (
	input  logic                      clk,
	input  rpb_pkg::lane_ctrl_t       ctrl,
	input  logic [rpb_pkg::CHAN_W-1:0] src,
	input  logic [rpb_pkg::CHAN_W-1:0] dst,
	input  logic [rpb_pkg::CHAN_W-1:0] src_alpha,
	output logic [rpb_pkg::CHAN_W-1:0] result
);
	import rpb_pkg::*;

	logic [CHAN_W-1:0] x_c, y_c, z_c, w_c, inv_c;
	logic [BASE_W-1:0] base_c;
	logic              comp_c;

	logic [CHAN_W-1:0] x_s1, y_s1, z_s1, w_s1;
	logic [BASE_W-1:0] base_s1, base_s2, base_s3;
	logic              comp_s1, comp_s2, comp_s3;
	logic [PROD_W-1:0] prod_s2;
	logic [CHAN_W-1:0] quot_s3;
	logic [CHAN_W-1:0] res_s4;

	logic [PROD_W-1:0] prod_c;
	logic [PROD_W:0]   div_tmp_c;
	logic [SUM_W-1:0]  sum_c;
	logic [CHAN_W-1:0] res_c;

	// operand select: base + (x*y + z*w)/255, or 255 - x*y/255 (screen)
	always_comb begin
		inv_c  = CHAN_MAX - src_alpha;
		x_c    = '0;
		y_c    = '0;
		z_c    = '0;
		w_c    = '0;
		base_c = '0;
		comp_c = 1'b0;
		case (ctrl.mode)
			MODE_COPY: begin
				base_c = {1'b0, src};
			end
			MODE_ADD: begin
				base_c = {1'b0, src} + {1'b0, dst};
			end
			MODE_MUL: begin
				x_c = dst;
				y_c = src;
			end
			MODE_SCREEN: begin
				if (ctrl.alpha_lane) begin
					base_c = {1'b0, src} + {1'b0, dst};
				end else begin
					x_c    = CHAN_MAX - dst;
					y_c    = CHAN_MAX - src;
					comp_c = 1'b1;
				end
			end
			MODE_PREMUL: begin
				x_c    = dst;
				y_c    = inv_c;
				base_c = {1'b0, src};
			end
			default: begin
				// alpha over, also for the unused codes
				z_c = dst;
				w_c = inv_c;
				if (ctrl.alpha_lane) begin
					base_c = {1'b0, src_alpha};
				end else begin
					x_c = src;
					y_c = src_alpha;
				end
			end
		endcase
	end

	// both products together never pass 255*255, so 16 bits hold the sum
	assign prod_c = x_s1 * y_s1 + z_s1 * w_s1;

	// exact p/255 for p below 65535
	assign div_tmp_c = {1'b0, prod_s2} + {{(CHAN_W+1){1'b0}}, prod_s2[PROD_W-1:CHAN_W]}
		+ {{PROD_W{1'b0}}, 1'b1};

	always_comb begin
		sum_c = {1'b0, base_s3} + {{(SUM_W-CHAN_W){1'b0}}, quot_s3};
		if (comp_s3) begin
			res_c = CHAN_MAX - quot_s3;
		end else if (sum_c > {{(SUM_W-CHAN_W){1'b0}}, CHAN_MAX}) begin
			res_c = CHAN_MAX;
		end else begin
			res_c = sum_c[CHAN_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			x_s1    <= x_c;
			y_s1    <= y_c;
			z_s1    <= z_c;
			w_s1    <= w_c;
			base_s1 <= base_c;
			comp_s1 <= comp_c;

			prod_s2 <= prod_c;
			base_s2 <= base_s1;
			comp_s2 <= comp_s1;

			quot_s3 <= div_tmp_c[PROD_W-1:CHAN_W];
			base_s3 <= base_s2;
			comp_s3 <= comp_s2;

			res_s4  <= res_c;
		end
	end

	assign result = res_s4;

endmodule

/* sv/rgba_pixel_blend_unit.sv */
`timescale 1ns / 1ps

// rgba8888 blend unit: takes a source and a destination pixel per transfer and
// returns one blended pixel per transfer under the mode held in the blend mode
// register (0 alpha over, 1 copy, 2 add, 3 multiply, 4 screen, 5 premultiplied
// over; 6 and 7 act as alpha over). a new pixel is taken every clock while the
// output is not stalled; each one passes in order through the four register
// stages of the channel lanes (operand select, multiply and add, divide by 255,
// saturate), the first of which is loaded by the transfer itself. back-pressure
// stalls the whole pipeline in place, nothing is dropped or repeated. write the
// mode only while the pipeline is empty.

module rgba_pixel_blend_unit (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata,     // blend_mode

	input  logic        s_tvalid,
	output logic        s_tready,
	// src_red, src_green, src_blue, src_alpha, dst_red, dst_green, dst_blue, dst_alpha
	input  logic [63:0] s_tdata,

	output logic        m_tvalid,
	input  logic        m_tready,
	// out_red, out_green, out_blue, out_alpha
	output logic [31:0] m_tdata
);
	import rpb_pkg::*;

	localparam int NCHAN = 4;

	logic [MODE_W-1:0] mode_q;
	logic              v_s1, v_s2, v_s3, v_s4;
	logic              adv;
	lane_ctrl_t        ctrl [NCHAN];

	// blend mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_OVER;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// the pipeline moves as one whenever the output stage is free or is taken
	assign adv      = !v_s4 || m_tready;
	assign s_tready = adv;
	assign m_tvalid = v_s4;

	// valid bits travel alongside the lane data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// one lane per channel, the last one being alpha
	for (genvar i = 0; i < NCHAN; i++) begin : g_lane
		assign ctrl[i].en         = adv;
		assign ctrl[i].mode       = mode_q;
		assign ctrl[i].alpha_lane = (i == NCHAN - 1);

		rpb_lane u_lane (
			.clk       (clk),
			.ctrl      (ctrl[i]),
			.src       (s_tdata[i*CHAN_W +: CHAN_W]),
			.dst       (s_tdata[(NCHAN+i)*CHAN_W +: CHAN_W]),
			.src_alpha (s_tdata[(NCHAN-1)*CHAN_W +: CHAN_W]),
			.result    (m_tdata[i*CHAN_W +: CHAN_W])
		);
	end

endmodule
